/* design/def_pkg.sv */
// shared constants, types and helpers of the directional emboss filter
package def_pkg;

    localparam int COORD_W    = 11;
    localparam int CHAN_W     = 8;
    localparam int LUMA_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int SIZE_W     = 12;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIFF_W     = LUMA_W + 1;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int GRAY_SHIFT = 26;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // luminance weights, unsigned Q8.16
    localparam logic [LUMA_W-1:0] LUMA_KR = LUMA_W'(19595);
    localparam logic [LUMA_W-1:0] LUMA_KG = LUMA_W'(38470);
    localparam logic [LUMA_W-1:0] LUMA_KB = LUMA_W'(7471);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = CFG_IDX_W'(4);

    // register reset values
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(480);
    localparam logic [STEP_W-1:0] RST_STEP_X       = 2'b11;
    localparam logic [STEP_W-1:0] RST_STEP_Y       = 2'b01;
    localparam logic [GAIN_W-1:0] RST_GAIN         = GAIN_W'(2048);

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // decoded step: nonzero flag and sign flag per axis
    typedef struct packed {
        logic x_nz;
        logic x_neg;
        logic y_nz;
        logic y_neg;
    } step_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               last;
    } result_t;

    function automatic logic [LUMA_W-1:0] luma_of(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        return LUMA_W'(r) * LUMA_KR + LUMA_W'(g) * LUMA_KG + LUMA_W'(b) * LUMA_KB;
    endfunction

endpackage

/* design/def_stream_if.sv */
// valid/ready stream interfaces for pixels in and results out
interface def_pixel_if;
    import def_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface def_result_if;
    import def_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
    logic               last_of_run;

    modport source (
        output valid, output col, output row, output red_out, output green_out,
        output blue_out, output last_of_run, input ready
    );
    modport sink (
        input valid, input col, input row, input red_out, input green_out,
        input blue_out, input last_of_run, output ready
    );
endinterface

/* design/directional_emboss_filter_top.sv */
// Pipeline: an accepted pixel passes stage B and stage C, then its results enter the queue.
// Throughput: one pixel per cycle while in_ready holds; the eight-entry result queue and
// the single output transfer per cycle set the pace, so pixels with two results slow input.
// Reset: counters, write pointer, pipeline and queue clear; registers take their defaults.
// The luma line store is not cleared and needs no clearing pass.
module directional_emboss_filter_top #(
    parameter int MAX_WIDTH  = def_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = def_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [def_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [def_pkg::CFG_DATA_W-1:0]  cfg_data,
    def_pixel_if.sink                       pixel,
    def_result_if.source                    result
);
    import def_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int RES_W = QCNT_W + 1;

    // configuration
    logic [CW-1:0]     width_eff;
    logic [RW-1:0]     height_eff;
    step_cfg_t         steps;
    logic [GAIN_W-1:0] gain;

    // raster position and store pointer
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] wr_pos_reg, wr_pos_next;
    logic [CW-1:0] x0;
    logic [RW-1:0] y0;

    // accept stage
    logic              accept;
    logic              in_ready;
    logic [LUMA_W-1:0] luma;
    logic [CW:0]       ux_own, ux_tgt;
    logic [RW:0]       uy_own, uy_tgt;
    logic              own_in, tgt_in;
    logic              lin_pos, lin_neg;
    logic [AW-1:0]     nb_dist;
    logic [AW:0]       rd_wrap;
    logic [AW-1:0]     rd_addr;
    logic [RES_W-1:0]  reserve;

    // stage B
    logic               b_valid_reg;
    logic [LUMA_W-1:0]  b_luma_reg;
    logic [CHAN_W-1:0]  b_red_reg, b_green_reg, b_blue_reg;
    logic [COORD_W-1:0] b_x_reg, b_y_reg, b_tx_reg, b_ty_reg;
    logic               b_tgt_reg, b_own_gray_reg, b_own_border_reg, b_nb_mem_reg;
    logic [LUMA_W-1:0]  mem_rdata;
    logic signed [DIFF_W-1:0] diff;

    // stage C
    logic               c_valid_reg;
    logic [CHAN_W-1:0]  c_red_reg, c_green_reg, c_blue_reg;
    logic [COORD_W-1:0] c_x_reg, c_y_reg, c_tx_reg, c_ty_reg;
    logic               c_tgt_reg, c_own_gray_reg, c_own_border_reg;
    logic [CHAN_W-1:0]  gray;
    logic               own_present;
    result_t            tgt_entry, own_entry;
    result_t            push_a, push_b;
    logic [1:0]         push_cnt;

    // queue
    logic              q_valid;
    result_t           q_head;
    logic [QCNT_W-1:0] q_count;

    def_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .steps      (steps),
        .gain       (gain)
    );

    // room for every result still in flight plus two more
    assign reserve  = RES_W'(q_count) + (RES_W'(b_valid_reg) << 1)
                    + (RES_W'(c_valid_reg) << 1) + RES_W'(2);
    assign in_ready = (reserve <= RES_W'(QUEUE_DEPTH));
    assign pixel.ready = in_ready;
    assign accept   = pixel.valid && in_ready;

    assign luma = luma_of(pixel.red_in, pixel.green_in, pixel.blue_in);

    // position of this pixel and of the next one, with wrap after a geometry change
    always_comb
    begin
        x0 = col_reg;
        y0 = row_reg;
        if (col_reg >= width_eff)
        begin
            x0 = '0;
            y0 = RW'(row_reg + 1'b1);
        end
        if (y0 >= height_eff)
            y0 = '0;

        col_next = CW'(x0 + 1'b1);
        row_next = y0;
        if (col_next >= width_eff)
        begin
            col_next = '0;
            row_next = RW'(y0 + 1'b1);
            if (row_next >= height_eff)
                row_next = '0;
        end
        wr_pos_next = (wr_pos_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_pos_reg + 1'b1);
    end

    // interior tests on coordinates offset by one so they stay unsigned
    always_comb
    begin
        ux_own = (CW + 1)'(x0) + (CW + 1)'(1);
        uy_own = (RW + 1)'(y0) + (RW + 1)'(1);
        if (!steps.x_nz)
            ux_tgt = ux_own;
        else if (steps.x_neg)
            ux_tgt = (CW + 1)'(x0) + (CW + 1)'(2);
        else
            ux_tgt = (CW + 1)'(x0);
        if (!steps.y_nz)
            uy_tgt = uy_own;
        else if (steps.y_neg)
            uy_tgt = (RW + 1)'(y0) + (RW + 1)'(2);
        else
            uy_tgt = (RW + 1)'(y0);

        own_in = (ux_own >= (CW + 1)'(2)) && (ux_own < (CW + 1)'(width_eff))
              && (uy_own >= (RW + 1)'(2)) && (uy_own < (RW + 1)'(height_eff));
        tgt_in = (ux_tgt >= (CW + 1)'(2)) && (ux_tgt < (CW + 1)'(width_eff))
              && (uy_tgt >= (RW + 1)'(2)) && (uy_tgt < (RW + 1)'(height_eff));
    end

    // raster distance to the neighbor and its direction
    always_comb
    begin
        lin_pos = steps.y_nz ? !steps.y_neg : (steps.x_nz && !steps.x_neg);
        lin_neg = steps.y_nz ? steps.y_neg : (steps.x_nz && steps.x_neg);
        if (!steps.y_nz)
            nb_dist = AW'(steps.x_nz);
        else if (!steps.x_nz)
            nb_dist = AW'(width_eff);
        else if (steps.x_neg == steps.y_neg)
            nb_dist = AW'(width_eff + 1'b1);
        else
            nb_dist = AW'(width_eff - 1'b1);

        rd_wrap = (AW + 1)'(wr_pos_reg) + (AW + 1)'(DEPTH) - (AW + 1)'(nb_dist);
        if (wr_pos_reg >= nb_dist)
            rd_addr = AW'(wr_pos_reg - nb_dist);
        else
            rd_addr = rd_wrap[AW-1:0];
    end

    def_luma_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_pos_reg),
        .wdata (luma),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            wr_pos_reg  <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                wr_pos_reg <= wr_pos_next;
            end
            b_valid_reg <= accept;
            c_valid_reg <= b_valid_reg;
        end
    end

    // stage B payload
    always_ff @(posedge clk)
    begin
        b_luma_reg       <= luma;
        b_red_reg        <= pixel.red_in;
        b_green_reg      <= pixel.green_in;
        b_blue_reg       <= pixel.blue_in;
        b_x_reg          <= COORD_W'(x0);
        b_y_reg          <= COORD_W'(y0);
        b_tx_reg         <= COORD_W'(ux_tgt - 1'b1);
        b_ty_reg         <= COORD_W'(uy_tgt - 1'b1);
        b_tgt_reg        <= lin_pos && tgt_in;
        b_own_gray_reg   <= own_in && !lin_pos;
        b_own_border_reg <= !own_in;
        b_nb_mem_reg     <= lin_neg;
    end

    // difference: delayed pixel minus this one, or this one minus earlier neighbor
    always_comb
    begin
        if (b_tgt_reg)
            diff = $signed({1'b0, mem_rdata}) - $signed({1'b0, b_luma_reg});
        else if (b_nb_mem_reg)
            diff = $signed({1'b0, b_luma_reg}) - $signed({1'b0, mem_rdata});
        else
            diff = '0;
    end

    def_gray_unit u_gray (
        .clk  (clk),
        .diff (diff),
        .gain (gain),
        .gray (gray)
    );

    // stage C payload
    always_ff @(posedge clk)
    begin
        c_red_reg        <= b_red_reg;
        c_green_reg      <= b_green_reg;
        c_blue_reg       <= b_blue_reg;
        c_x_reg          <= b_x_reg;
        c_y_reg          <= b_y_reg;
        c_tx_reg         <= b_tx_reg;
        c_ty_reg         <= b_ty_reg;
        c_tgt_reg        <= b_tgt_reg;
        c_own_gray_reg   <= b_own_gray_reg;
        c_own_border_reg <= b_own_border_reg;
    end

    // build results, delayed interior result first
    always_comb
    begin
        own_present = c_own_border_reg || c_own_gray_reg;

        tgt_entry.col   = c_tx_reg;
        tgt_entry.row   = c_ty_reg;
        tgt_entry.red   = gray;
        tgt_entry.green = gray;
        tgt_entry.blue  = gray;
        tgt_entry.last  = !own_present;

        own_entry.col   = c_x_reg;
        own_entry.row   = c_y_reg;
        own_entry.red   = c_own_border_reg ? c_red_reg : gray;
        own_entry.green = c_own_border_reg ? c_green_reg : gray;
        own_entry.blue  = c_own_border_reg ? c_blue_reg : gray;
        own_entry.last  = 1'b1;

        push_a   = c_tgt_reg ? tgt_entry : own_entry;
        push_b   = own_entry;
        push_cnt = c_valid_reg ? ({1'b0, c_tgt_reg} + {1'b0, own_present}) : 2'd0;
    end

    def_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (push_b),
        .pop      (result.ready),
        .valid    (q_valid),
        .head     (q_head),
        .count    (q_count)
    );

    // output channel
    assign result.valid       = q_valid;
    assign result.col         = q_head.col;
    assign result.row         = q_head.row;
    assign result.red_out     = q_head.red;
    assign result.green_out   = q_head.green;
    assign result.blue_out    = q_head.blue;
    assign result.last_of_run = q_head.last;

endmodule

/* design/def_cfg_regs.sv */
// configuration registers and effective frame geometry
module def_cfg_regs #(
    parameter int MAX_WIDTH  = def_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = def_pkg::DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [def_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [def_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [CW-1:0]                   width_eff,
    output logic [RW-1:0]                   height_eff,
    output def_pkg::step_cfg_t              steps,
    output logic [def_pkg::GAIN_W-1:0]      gain
);
    import def_pkg::*;

    localparam int WSW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int HSW = (RW > SIZE_W) ? RW : SIZE_W;

    logic [SIZE_W-1:0] frame_width_reg, frame_width_next;
    logic [SIZE_W-1:0] frame_height_reg, frame_height_next;
    logic [STEP_W-1:0] step_x_reg, step_x_next;
    logic [STEP_W-1:0] step_y_reg, step_y_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [WSW-1:0]    w_ext;
    logic [HSW-1:0]    h_ext;

    // register writes
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        step_x_next       = step_x_reg;
        step_y_next       = step_y_reg;
        gain_next         = gain_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data[SIZE_W-1:0];
                REG_STEP_X:       step_x_next       = cfg_data[STEP_W-1:0];
                REG_STEP_Y:       step_y_next       = cfg_data[STEP_W-1:0];
                REG_GAIN:         gain_next         = cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            step_x_reg       <= RST_STEP_X;
            step_y_reg       <= RST_STEP_Y;
            gain_reg         <= RST_GAIN;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            step_x_reg       <= step_x_next;
            step_y_reg       <= step_y_next;
            gain_reg         <= gain_next;
        end
    end

    // zero counts as one, oversize saturates
    assign w_ext = WSW'(frame_width_reg);
    assign h_ext = HSW'(frame_height_reg);

    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = CW'(1);
        else if (w_ext > WSW'(MAX_WIDTH))
            width_eff = CW'(MAX_WIDTH);
        else
            width_eff = CW'(w_ext);

        if (frame_height_reg == '0)
            height_eff = RW'(1);
        else if (h_ext > HSW'(MAX_HEIGHT))
            height_eff = RW'(MAX_HEIGHT);
        else
            height_eff = RW'(h_ext);
    end

    // unused code 10b decodes as minus one
    assign steps.x_nz  = (step_x_reg != '0);
    assign steps.x_neg = step_x_reg[1];
    assign steps.y_nz  = (step_y_reg != '0);
    assign steps.y_neg = step_y_reg[1];
    assign gain        = gain_reg;

endmodule

/* design/def_luma_store.sv */
// line store of luminances, one write and one registered read per cycle
module def_luma_store #(
    parameter int DEPTH = def_pkg::DEF_MAX_WIDTH + 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [def_pkg::LUMA_W-1:0]   wdata,
    input  logic [AW-1:0]                raddr,
    output logic [def_pkg::LUMA_W-1:0]   rdata
);
    import def_pkg::*;

    logic [LUMA_W-1:0] mem [DEPTH];
    logic [LUMA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/def_gray_unit.sv */
// registered luminance difference times gain, then offset and clamp
module def_gray_unit (
    input  logic                               clk,
    input  logic signed [def_pkg::DIFF_W-1:0]  diff,
    input  logic [def_pkg::GAIN_W-1:0]         gain,
    output logic [def_pkg::CHAN_W-1:0]         gray
);
    import def_pkg::*;

    localparam int HI_W = PROD_W - GRAY_SHIFT;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic        [HI_W-1:0]   hi;
    logic signed [HI_W:0]     level;

    // product stage
    assign prod_next = diff * $signed({1'b0, gain});

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // floor by arithmetic shift, then add mid gray
    assign hi    = prod_reg[PROD_W-1:GRAY_SHIFT];
    assign level = $signed({hi[HI_W-1], hi}) + $signed((HI_W + 1)'(128));

    // clamp to channel range
    always_comb
    begin
        if (level[HI_W])
            gray = '0;
        else if (level[HI_W-1:CHAN_W] != '0)
            gray = '1;
        else
            gray = level[CHAN_W-1:0];
    end

endmodule

/* design/def_out_queue.sv */
// result queue, up to two pushes and one pop per cycle
module def_out_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [1:0]                  push_cnt,
    input  def_pkg::result_t            push_a,
    input  def_pkg::result_t            push_b,
    input  logic                        pop,
    output logic                        valid,
    output def_pkg::result_t            head,
    output logic [def_pkg::QCNT_W-1:0]  count
);
    import def_pkg::*;

    result_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wr_ptr_b;
    logic                pop_fire;

    assign pop_fire = pop && (count_reg != '0);
    assign wr_ptr_b = QPTR_W'(wr_ptr_reg + 1'b1);

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            slot_reg[wr_ptr_reg] <= push_a;
        if (push_cnt == 2'd2)
            slot_reg[wr_ptr_b] <= push_b;
    end

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = QPTR_W'(wr_ptr_reg + QPTR_W'(push_cnt));
        rd_ptr_next = pop_fire ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = QCNT_W'(count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop_fire));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* design/def_checker.sv */
// port-level checks of the emboss filter and their attachment to the top level
module def_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [def_pkg::COORD_W-1:0]     col,
    input logic [def_pkg::COORD_W-1:0]     row,
    input logic [def_pkg::CHAN_W-1:0]      red,
    input logic [def_pkg::CHAN_W-1:0]      green,
    input logic [def_pkg::CHAN_W-1:0]      blue,
    input logic                            last
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable({col, row, red, green, blue, last}))
        else $error("result changed while stalled");

    // the first of two results is always a gray interior pixel
    a_first_gray: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> red == green && green == blue)
        else $error("non-final result is not gray");

    // the second result of a pair is already waiting
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last |=> res_valid)
        else $error("second result of a pair missing");

    // nothing is offered while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result offered during reset");

endmodule

bind directional_emboss_filter_top def_checker u_def_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .col       (result.col),
    .row       (result.row),
    .red       (result.red_out),
    .green     (result.green_out),
    .blue      (result.blue_out),
    .last      (result.last_of_run)
);

/* tb/emboss_checker.sv */
// emboss checker: mirrors register writes, predicts each pixel's results and compares them
module emboss_checker
    import def_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    def_pixel_if                  pixel,
    def_result_if                 result,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = DEF_MAX_WIDTH + 2;

    // register mirror
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [STEP_W-1:0] step_x_reg;
    logic [STEP_W-1:0] step_y_reg;
    logic [GAIN_W-1:0] gain_reg;

    // luminance line and raster position
    logic [LUMA_W-1:0] luma_line [LINE_DEPTH];
    int                col_pos;
    int                row_pos;
    int                wr_ptr;

    result_t gray_expect_q [$];
    result_t want;
    result_t got;
    int      errors;

    // register value to frame size, zero taken as one, saturated at the maximum
    function automatic int dim_clip(input logic [SIZE_W-1:0] v, input int maxv);
        if (int'(v) < 1)
        begin
            return 1;
        end
        if (int'(v) > maxv)
        begin
            return maxv;
        end
        return int'(v);
    endfunction

    // two-bit step code as signed offset, the unused negative code saturates
    function automatic int step_of(input logic [STEP_W-1:0] code);
        int v;
        v = int'($signed(code));
        if (v < -1)
        begin
            v = -1;
        end
        return v;
    endfunction

    function automatic bit on_interior(input int x, input int y, input int w, input int h);
        return x >= 1 && x <= w - 2 && y >= 1 && y <= h - 2;
    endfunction

    // 128 plus scaled luminance difference, floored and clamped to a byte
    function automatic logic [CHAN_W-1:0] emboss_gray(input logic [LUMA_W-1:0] own,
                                                      input logic [LUMA_W-1:0] nb,
                                                      input logic [GAIN_W-1:0] k);
        longint acc;
        acc = (longint'(128) <<< GRAY_SHIFT) + (longint'(own) - longint'(nb)) * longint'(k);
        if (acc < 0)
        begin
            return '0;
        end
        acc = acc >>> GRAY_SHIFT;
        if (acc > 255)
        begin
            return '1;
        end
        return CHAN_W'(acc);
    endfunction

    // one accepted pixel: queue the results it causes
    task automatic emboss_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                input logic [CHAN_W-1:0] b);
        int                w;
        int                h;
        int                sx;
        int                sy;
        int                lin;
        int                x;
        int                y;
        int                tx;
        int                ty;
        int                n;
        logic [LUMA_W-1:0] luma;
        logic [LUMA_W-1:0] nb;
        logic [CHAN_W-1:0] gv;
        result_t           outs [2];
        w = dim_clip(width_reg, DEF_MAX_WIDTH);
        h = dim_clip(height_reg, DEF_MAX_HEIGHT);
        sx = step_of(step_x_reg);
        sy = step_of(step_y_reg);
        luma = LUMA_W'(19595 * int'(r) + 38470 * int'(g) + 7471 * int'(b));
        lin = sy * w + sx;
        n = 0;

        // counters left beyond a shrunken frame wrap first
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
        begin
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;

        // earlier interior pixel whose neighbour is this one
        if (lin > 0)
        begin
            tx = x - sx;
            ty = y - sy;
            if (on_interior(tx, ty, w, h))
            begin
                gv = emboss_gray(luma_line[(wr_ptr + LINE_DEPTH - lin) % LINE_DEPTH], luma,
                                 gain_reg);
                outs[n] = '{col: COORD_W'(tx), row: COORD_W'(ty), red: gv, green: gv,
                            blue: gv, last: 1'b0};
                n++;
            end
        end

        luma_line[wr_ptr] = luma;

        // the pixel itself: gray when its neighbour is known, original on the border
        if (on_interior(x, y, w, h))
        begin
            if (lin <= 0)
            begin
                nb = (lin < 0) ? luma_line[(wr_ptr + LINE_DEPTH + lin) % LINE_DEPTH] : luma;
                gv = emboss_gray(luma, nb, gain_reg);
                outs[n] = '{col: COORD_W'(x), row: COORD_W'(y), red: gv, green: gv,
                            blue: gv, last: 1'b0};
                n++;
            end
        end
        else
        begin
            outs[n] = '{col: COORD_W'(x), row: COORD_W'(y), red: r, green: g, blue: b,
                        last: 1'b0};
            n++;
        end

        if (n > 0)
        begin
            outs[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            gray_expect_q.push_back(outs[i]);
        end

        // advance raster position
        wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
        end
    endtask

    // watch register writes and both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            step_x_reg = RST_STEP_X;
            step_y_reg = RST_STEP_Y;
            gain_reg = RST_GAIN;
            col_pos = 0;
            row_pos = 0;
            wr_ptr = 0;
            errors = 0;
            gray_expect_q.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg = cfg_data[SIZE_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_data[SIZE_W-1:0];
                    REG_STEP_X:       step_x_reg = cfg_data[STEP_W-1:0];
                    REG_STEP_Y:       step_y_reg = cfg_data[STEP_W-1:0];
                    REG_GAIN:         gain_reg = cfg_data[GAIN_W-1:0];
                    default:          ;
                endcase
            end

            // pixel transfer
            if (pixel.valid && pixel.ready)
            begin
                emboss_pixel(pixel.red_in, pixel.green_in, pixel.blue_in);
            end

            // result transfer against the oldest expectation
            if (result.valid && result.ready)
            begin
                got = '{col: result.col, row: result.row, red: result.red_out,
                        green: result.green_out, blue: result.blue_out,
                        last: result.last_of_run};
                if (gray_expect_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result: col %0d row %0d rgb %0d/%0d/%0d last %0b",
                                 got.col, got.row, got.red, got.green, got.blue, got.last);
                    end
                end
                else
                begin
                    want = gray_expect_q.pop_front();
                    if (got.col !== want.col || got.row !== want.row ||
                        got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("result mismatch: expected col %0d row %0d rgb %0d/%0d/%0d last %0b",
                                     want.col, want.row, want.red, want.green, want.blue,
                                     want.last);
                            $display("                 got      col %0d row %0d rgb %0d/%0d/%0d last %0b",
                                     got.col, got.row, got.red, got.green, got.blue, got.last);
                        end
                    end
                end
            end

            fail_count <= errors;
            outstanding <= gray_expect_q.size();
        end
    end

endmodule

/* tb/tb_directional_emboss_filter_top.sv */
// testbench top: clock, reset, register writes, pixel and result stimulus and the verdict
module tb_directional_emboss_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import def_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_PIXELS = 1150;
    localparam int SETTLE_CYCLES = 8;
    localparam int GAIN_TOP = 51200;

    localparam logic [STEP_W-1:0] STEP_FWD  = 2'b01;
    localparam logic [STEP_W-1:0] STEP_NONE = 2'b00;
    localparam logic [STEP_W-1:0] STEP_BACK = 2'b11;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int cycles = 0;
    int sent_total;
    int random_sent;
    bit src_idle;
    bit sink_idle;

    def_pixel_if  pixel_ch ();
    def_result_if result_ch ();

    directional_emboss_filter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    emboss_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel       (pixel_ch),
        .result      (result_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 15) == 0)
        begin
            return $urandom_range(15, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    // channel value, biased toward the extremes
    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int dim_of(input int v);
        if (v < 1)
        begin
            return 1;
        end
        if (v > DEF_MAX_WIDTH)
        begin
            return DEF_MAX_WIDTH;
        end
        return v;
    endfunction

    // result ready with random stalls
    initial
    begin
        int hold;
        hold = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (sink_idle && $urandom_range(0, 5) == 0)
                begin
                    hold = gap_len();
                end
            end
        end
    end

    // one register write, entered and left just after a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold off until every expected result has arrived and the pipeline is empty
    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int w, input int h, input logic [STEP_W-1:0] sx,
                             input logic [STEP_W-1:0] sy, input int k);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_STEP_X, int'(sx));
        write_reg(REG_STEP_Y, int'(sy));
        write_reg(REG_GAIN, k);
    endtask

    // one pixel transfer, with an optional gap ahead of it
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        int gap;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            gap = gap_len();
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.red_in <= r;
        pixel_ch.green_in <= g;
        pixel_ch.blue_in <= b;
        @(negedge clk);
        while (!pixel_ch.ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        sent_total++;
    endtask

    // random geometry, step and gain, then a whole frame or a piece of one
    task automatic random_phase();
        int                w;
        int                h;
        int                k;
        int                n;
        int                frame_px;
        logic [STEP_W-1:0] sx;
        logic [STEP_W-1:0] sy;
        bit                wide;
        wide = 1'b0;
        case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 2);
            1:
            begin
                w = $urandom_range(2048, 4095);
                wide = 1'b1;
            end
            2, 3:    w = $urandom_range(13, 40);
            default: w = $urandom_range(3, 12);
        endcase
        case ($urandom_range(0, 9))
            0:       h = $urandom_range(0, 2);
            1:       h = $urandom_range(2048, 4095);
            default: h = $urandom_range(3, 10);
        endcase
        // neighbour reads must only reach pixels already stored
        if (wide || (dim_of(w) >= 3 && dim_of(h) >= 3 && dim_of(w) + 2 > sent_total))
        begin
            h = $urandom_range(0, 2);
        end
        sx = STEP_W'($urandom_range(0, 3));
        sy = STEP_W'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       k = 0;
            1:       k = GAIN_TOP;
            2:       k = 65535;
            3:       k = $urandom_range(0, 65535);
            default: k = $urandom_range(256, 8192);
        endcase
        frame_px = dim_of(w) * dim_of(h);
        if (frame_px <= 150 && $urandom_range(0, 3) != 0)
        begin
            n = frame_px;
        end
        else
        begin
            n = $urandom_range(4, 60);
        end

        configure(w, h, sx, sy, k);
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++)
        begin
            send_pixel(rand_chan(), rand_chan(), rand_chan());
        end
        pixel_ch.valid <= 1'b0;
        random_sent += n;
    endtask

    // stimulus and verdict
    initial
    begin
        cfg_we <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= '0;
        pixel_ch.valid <= 1'b0;
        pixel_ch.red_in <= '0;
        pixel_ch.green_in <= '0;
        pixel_ch.blue_in <= '0;
        rst_n <= 1'b0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        sent_total = 0;
        random_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3, forward step, top gain: dark center against a white neighbour,
        // the last pixel releases the delayed center result ahead of its own
        configure(3, 3, STEP_FWD, STEP_FWD, GAIN_TOP);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd64, 8'd32);
        send_pixel(8'd1, 8'd2, 8'd4);
        send_pixel(8'd255, 8'd255, 8'd255);
        pixel_ch.valid <= 1'b0;

        // 3x3 with zero step: center compared with itself
        configure(3, 3, STEP_NONE, STEP_NONE, 65535);
        for (int i = 0; i < 9; i++)
        begin
            send_pixel(rand_chan(), rand_chan(), rand_chan());
        end
        pixel_ch.valid <= 1'b0;

        // 2x2 frame: all border, passed through
        configure(2, 2, STEP_BACK, STEP_BACK, 0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd170);
        send_pixel(8'd85, 8'd170, 8'd85);
        pixel_ch.valid <= 1'b0;

        // oversized width saturates, tallest frame, first row only
        configure(4095, 2048, STEP_FWD, STEP_FWD, 1024);
        for (int i = 0; i < 16; i++)
        begin
            send_pixel(rand_chan(), rand_chan(), rand_chan());
        end
        pixel_ch.valid <= 1'b0;

        while (random_sent < RANDOM_PIXELS)
        begin
            random_phase();
        end

        wait_drained();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* directional_emboss_filter_top.f */
design/def_pkg.sv
design/def_stream_if.sv
design/def_cfg_regs.sv
design/def_luma_store.sv
design/def_gray_unit.sv
design/def_out_queue.sv
design/directional_emboss_filter_top.sv
design/def_checker.sv
tb/emboss_checker.sv
tb/tb_directional_emboss_filter_top.sv
